### hw/rtl/wsbtc_pkg.sv
package wsbtc_pkg;

    localparam int SPEED_BITS_DEF = 16;
    localparam int CLAMP_HI       = 100;

    localparam int THR_W  = 15;
    localparam int GAIN_W = 8;
    localparam int CFG_W  = 15;
    localparam int CFG_IDX_W = 3;

    localparam int BRAKE_W = 8;
    localparam int ACCEL_W = 7;
    localparam int FLAG_W  = 3;
    localparam int OUT_W   = 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLIP_ABS  = 3'd0,
        CFG_SLIP_TC   = 3'd1,
        CFG_YAW_THR   = 3'd2,
        CFG_GAIN_ABS  = 3'd3,
        CFG_GAIN_TC   = 3'd4,
        CFG_GAIN_STAB = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [THR_W-1:0]  slip_threshold_abs;
        logic [THR_W-1:0]  slip_threshold_traction;
        logic [THR_W-1:0]  yaw_threshold;
        logic [GAIN_W-1:0] gain_abs;
        logic [GAIN_W-1:0] gain_traction;
        logic [GAIN_W-1:0] gain_stability;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        slip_threshold_abs:      15'd2,
        slip_threshold_traction: 15'd2,
        yaw_threshold:           15'd10,
        gain_abs:                8'd20,
        gain_traction:           8'd20,
        gain_stability:          8'd15
    };

    typedef struct packed {
        logic abs_enable;
        logic traction_enable;
        logic stability_enable;
    } flags_t;

endpackage

### hw/rtl/wheel_slip_brake_traction_control.sv
// Wheel slip brake and traction control. One control sample per request on the
// slave stream gives one result on the master stream. The block accepts a new
// sample every cycle while s_tready is high; a sample passes an input register,
// the correction logic and a result register, whose output drives the master
// stream. A stall on the master side holds the result register and, once the
// input register is also full, drops s_tready. The six control registers are
// written through cfg_wr_en / cfg_index / cfg_data and must only change while
// no sample is in flight.
module wheel_slip_brake_traction_control
    import wsbtc_pkg::*;
#(
    parameter int SPEED_BITS = SPEED_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // vehicle_speed, wheel_front_left, wheel_front_right, wheel_rear_left,
    // wheel_rear_right, yaw_rate, driver_brake, driver_accel, zero fill
    input  logic [((6*SPEED_BITS+16+7)/8)*8-1:0] s_tdata,
    // abs_enable, traction_enable, stability_enable
    input  logic [FLAG_W-1:0]          s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // brake_front_left, brake_front_right, brake_rear_left, brake_rear_right,
    // accel_correction, zero fill
    output logic [OUT_W-1:0]           m_tdata
);

    localparam int FIELD_W = 6*SPEED_BITS + 16;
    localparam int DB_LO   = 6*SPEED_BITS;
    localparam int DA_LO   = 6*SPEED_BITS + 8;

    cfg_t                       cfg_reg;
    logic                       in_valid_reg;
    logic [FIELD_W-1:0]         in_data_reg;
    logic [FLAG_W-1:0]          in_user_reg;
    logic                       out_valid_reg;
    logic [OUT_W-1:0]           out_data_reg;
    logic [OUT_W-1:0]           out_data_next;
    logic                       out_ready;
    logic                       in_accept;
    logic [3:0][SPEED_BITS-1:0] wheel;
    logic [3:0][BRAKE_W-1:0]    brake;
    logic [ACCEL_W-1:0]         accel;
    flags_t                     flags;

    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SLIP_ABS:  cfg_reg.slip_threshold_abs      <= cfg_data;
                CFG_SLIP_TC:   cfg_reg.slip_threshold_traction <= cfg_data;
                CFG_YAW_THR:   cfg_reg.yaw_threshold           <= cfg_data;
                CFG_GAIN_ABS:  cfg_reg.gain_abs                <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_TC:   cfg_reg.gain_traction           <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_STAB: cfg_reg.gain_stability          <= cfg_data[GAIN_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_ready)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_data_reg <= s_tdata[FIELD_W-1:0];
            in_user_reg <= s_tuser;
        end
        if (out_ready && in_valid_reg)
            out_data_reg <= out_data_next;
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            wheel[k] = in_data_reg[(k+1)*SPEED_BITS +: SPEED_BITS];
    end

    assign flags.abs_enable       = in_user_reg[0];
    assign flags.traction_enable  = in_user_reg[1];
    assign flags.stability_enable = in_user_reg[2];

    wsbtc_core #(
        .SPEED_BITS(SPEED_BITS)
    ) u_core (
        .cfg              (cfg_reg),
        .vehicle_speed    (in_data_reg[SPEED_BITS-1:0]),
        .wheel            (wheel),
        .yaw_rate         (in_data_reg[5*SPEED_BITS +: SPEED_BITS]),
        .driver_brake     (in_data_reg[DB_LO +: 8]),
        .driver_accel     (in_data_reg[DA_LO +: 8]),
        .flags            (flags),
        .brake            (brake),
        .accel_correction (accel)
    );

    assign out_data_next = {1'b0, accel, brake[3], brake[2], brake[1], brake[0]};

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### hw/rtl/wsbtc_core.sv
module wsbtc_core
    import wsbtc_pkg::*;
#(
    parameter int SPEED_BITS = SPEED_BITS_DEF
)
(
    input  cfg_t                              cfg,
    input  logic [SPEED_BITS-1:0]             vehicle_speed,
    input  logic [3:0][SPEED_BITS-1:0]        wheel,
    input  logic [SPEED_BITS-1:0]             yaw_rate,
    input  logic [BRAKE_W-1:0]                driver_brake,
    input  logic [7:0]                        driver_accel,
    input  flags_t                            flags,
    output logic [3:0][BRAKE_W-1:0]           brake,
    output logic [ACCEL_W-1:0]                accel_correction
);

    localparam int CMP_W  = ((SPEED_BITS > THR_W) ? SPEED_BITS : THR_W) + 2;
    localparam int PROD_W = CMP_W + GAIN_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int EXT_W  = CMP_W - SPEED_BITS;
    localparam int TEXT_W = CMP_W - THR_W;
    localparam int WHEEL_RL = 2;
    localparam int WHEEL_RR = 3;

    function automatic logic signed [SUM_W-1:0] clamp_hi(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] r;
        if (x < 0)
            r = '0;
        else if (x > SUM_W'(CLAMP_HI))
            r = SUM_W'(CLAMP_HI);
        else
            r = x;
        return r;
    endfunction

    logic signed [CMP_W-1:0]  vs_x;
    logic signed [CMP_W-1:0]  yaw_x;
    logic signed [CMP_W-1:0]  ayaw;
    logic signed [CMP_W-1:0]  w_x      [4];
    logic signed [CMP_W-1:0]  ndiff    [4];
    logic                     slip     [4];
    logic signed [PROD_W-1:0] abs_prod [4];
    logic signed [SUM_W-1:0]  b        [4];
    logic signed [CMP_W-1:0]  thr_abs_x;
    logic signed [CMP_W-1:0]  thr_tc_x;
    logic signed [CMP_W-1:0]  thr_yaw_x;
    logic signed [8:0]        g_abs;
    logic signed [8:0]        g_tc;
    logic signed [8:0]        g_stab;
    logic                     stab_hit;
    logic signed [PROD_W-1:0] stab_prod;
    logic signed [SUM_W-1:0]  stab_corr;
    logic                     abs_run;
    logic signed [CMP_W-1:0]  rsum;
    logic signed [CMP_W-1:0]  rsum_adj;
    logic signed [CMP_W-1:0]  avg;
    logic signed [CMP_W-1:0]  tdiff;
    logic signed [PROD_W-1:0] tc_prod;
    logic signed [SUM_W-1:0]  accel_x;

    assign vs_x      = {{EXT_W{vehicle_speed[SPEED_BITS-1]}}, vehicle_speed};
    assign yaw_x     = {{EXT_W{yaw_rate[SPEED_BITS-1]}}, yaw_rate};
    assign ayaw      = yaw_x[CMP_W-1] ? -yaw_x : yaw_x;
    assign thr_abs_x = {{TEXT_W{1'b0}}, cfg.slip_threshold_abs};
    assign thr_tc_x  = {{TEXT_W{1'b0}}, cfg.slip_threshold_traction};
    assign thr_yaw_x = {{TEXT_W{1'b0}}, cfg.yaw_threshold};
    assign g_abs     = {1'b0, cfg.gain_abs};
    assign g_tc      = {1'b0, cfg.gain_traction};
    assign g_stab    = {1'b0, cfg.gain_stability};

    // Stability correction from the excess yaw magnitude
    assign stab_hit  = flags.stability_enable && (ayaw > thr_yaw_x);
    assign stab_prod = PROD_W'(ayaw - thr_yaw_x) * PROD_W'(g_stab);
    assign stab_corr = clamp_hi(SUM_W'(stab_prod));

    assign abs_run = (driver_brake != '0) && flags.abs_enable;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            w_x[k]      = {{EXT_W{wheel[k][SPEED_BITS-1]}}, wheel[k]};
            ndiff[k]    = w_x[k] - vs_x;
            slip[k]     = (vs_x - w_x[k]) > thr_abs_x;
            abs_prod[k] = PROD_W'(ndiff[k]) * PROD_W'(g_abs);
            b[k]        = SUM_W'({1'b0, driver_brake});
            if (stab_hit)
            begin
                if ((k == WHEEL_RR && !yaw_x[CMP_W-1] && yaw_x != '0) ||
                    (k == WHEEL_RL && (yaw_x[CMP_W-1] || yaw_x == '0)))
                    b[k] = clamp_hi(b[k] + stab_corr);
                if (slip[k])
                    b[k] = clamp_hi(b[k] + SUM_W'(abs_prod[k]));
            end
            if (abs_run && slip[k])
                b[k] = clamp_hi(b[k] + SUM_W'(abs_prod[k]));
            brake[k] = b[k][BRAKE_W-1:0];
        end
    end

    // Rear average rounds toward zero: bias negative sums by one before the shift
    assign rsum     = w_x[WHEEL_RL] + w_x[WHEEL_RR];
    assign rsum_adj = rsum + {{(CMP_W-1){1'b0}}, rsum[CMP_W-1]};
    assign avg      = rsum_adj >>> 1;
    assign tdiff    = avg - vs_x;
    assign tc_prod  = PROD_W'(tdiff) * PROD_W'(g_tc);

    always_comb
    begin
        priority if ((driver_accel != '0) && flags.traction_enable)
        begin
            if (tdiff > thr_tc_x)
                accel_x = clamp_hi(SUM_W'(tc_prod));
            else
                accel_x = '0;
        end
        else if (stab_hit)
            accel_x = stab_corr;
        else
            accel_x = '0;
    end

    assign accel_correction = accel_x[ACCEL_W-1:0];

endmodule

### hw/rtl/wsbtc_checker.sv
module wsbtc_checker
    import wsbtc_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [OUT_W-1:0]           m_tdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A request accepted must be followed by a valid result on the master side
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("accepted request produced no result");

    // Input back-pressure only while a result is pending
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with output free");

    // Accel correction stays in range, fill bit stays clear
    a_accel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[38:32] <= 7'd100) && !m_tdata[39])
        else $error("accel correction out of range");

endmodule

bind wheel_slip_brake_traction_control wsbtc_checker u_wsbtc_checker (.*);
